/* design/ipp_pkg.sv */
// Package for the isometric point projector.
// Types, register indexes and reset constants; no dependencies.
package ipp_pkg;

    localparam int CfgIndexW = 3;
    localparam int CfgDataW  = 16;

    typedef enum logic [CfgIndexW-1:0] {
        REG_OFFSET_X      = 3'd0,
        REG_OFFSET_Y      = 3'd1,
        REG_OFFSET_Z      = 3'd2,
        REG_CENTER_X      = 3'd3,
        REG_CENTER_Y      = 3'd4,
        REG_SCREEN_WIDTH  = 3'd5,
        REG_SCREEN_HEIGHT = 3'd6
    } cfg_index_t;

    localparam logic signed [12:0] CENTER_X_RST      = 13'sd320;
    localparam logic signed [12:0] CENTER_Y_RST      = 13'sd240;
    localparam logic        [11:0] SCREEN_WIDTH_RST  = 12'd640;
    localparam logic        [11:0] SCREEN_HEIGHT_RST = 12'd480;

    localparam logic signed [15:0] BOX_HIGH_INIT = 16'sd32767;
    localparam logic signed [15:0] BOX_LOW_INIT  = -16'sd32767;

    // Bounding box of screen coordinates
    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic signed [15:0] top;
        logic signed [15:0] bottom;
    } box_t;

    // One projected item
    typedef struct packed {
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic signed [18:0] depth;
        logic               on_screen;
        box_t               box;
    } proj_res_t;

endpackage

/* design/ipp_proj.sv */
// Projection datapath: offsets, isometric mapping, visibility and box fold.
// Pure combinational; uses ipp_pkg.
module ipp_proj (
    input  logic signed [15:0] point_x,
    input  logic signed [15:0] point_y,
    input  logic signed [15:0] point_z,
    input  logic               new_model,
    input  logic signed [15:0] offset_x,
    input  logic signed [15:0] offset_y,
    input  logic signed [15:0] offset_z,
    input  logic signed [12:0] center_x,
    input  logic signed [12:0] center_y,
    input  logic        [11:0] screen_width,
    input  logic        [11:0] screen_height,
    input  ipp_pkg::box_t      box_cur,
    output ipp_pkg::proj_res_t res
);
    import ipp_pkg::*;

    logic signed [16:0] cx;
    logic signed [16:0] cy;
    logic signed [17:0] cz;
    logic signed [17:0] dxy;
    logic signed [17:0] sxy;
    logic signed [23:0] tx;
    logic signed [23:0] ty;
    logic signed [23:0] tx_b;
    logic signed [23:0] ty_b;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [16:0] w_s;
    logic signed [16:0] h_s;
    box_t               box_base;

    always_comb
    begin
        cx  = 17'(point_x) + 17'(offset_x);
        cy  = 17'(point_y) + 17'(offset_y);
        cz  = -(18'(point_z) + 18'(offset_z));
        dxy = 18'(cx) - 18'(cy);
        sxy = 18'(cx) + 18'(cy);

        tx = 24'(dxy) * 24'sd24;
        ty = 24'(sxy) * 24'sd12 - 24'(cz) * 24'sd30;

        // divide by 512 rounding toward zero: bias negatives before the shift
        tx_b = tx + (tx[23] ? 24'sd511 : 24'sd0);
        ty_b = ty + (ty[23] ? 24'sd511 : 24'sd0);
        sx   = 16'(tx_b >>> 9) + 16'(center_x);
        sy   = 16'(ty_b >>> 9) + 16'(center_y);

        w_s = $signed({5'd0, screen_width});
        h_s = $signed({5'd0, screen_height});

        res.screen_x  = sx;
        res.screen_y  = sy;
        res.depth     = 19'(cz) - 19'(cx) - 19'(cy);
        res.on_screen = (sx > 16'sd0) && (17'(sx) < w_s) &&
                        (sy > 16'sd0) && (17'(sy) < h_s);

        if (new_model)
        begin
            box_base.left   = BOX_HIGH_INIT;
            box_base.right  = BOX_LOW_INIT;
            box_base.top    = BOX_HIGH_INIT;
            box_base.bottom = BOX_LOW_INIT;
        end
        else
        begin
            box_base = box_cur;
        end

        res.box.left   = (sx < box_base.left)   ? sx : box_base.left;
        res.box.right  = (sx > box_base.right)  ? sx : box_base.right;
        res.box.top    = (sy < box_base.top)    ? sy : box_base.top;
        res.box.bottom = (sy > box_base.bottom) ? sy : box_base.bottom;
    end

endmodule

/* design/isometric_point_projector.sv */
// Top level of the isometric point projector: config registers, input
// register, projection datapath and result register. Uses ipp_pkg, ipp_proj.
//
//  channel  | signals                                   | item
//  ---------+-------------------------------------------+----------------------
//  in       | in_valid, in_stall, point_x/y/z, new_model | one model point
//  out      | out_valid, out_stall, screen_x .. box_*    | one projected point
//  cfg      | cfg_we, cfg_index, cfg_data                | one register write
//
// One item per cycle sustained while out_stall is low; an item passes the input
// register, then the projection and box fold into the result register.
// rst_n clears valids, config to defaults and the box to 32767 / -32767.
// A stalled result holds; the input register still fills behind it, and
// in_stall rises only when both registers are full and out_stall is high.
module isometric_point_projector (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [ipp_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [ipp_pkg::CfgDataW-1:0]  cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] point_x,
    input  logic signed [15:0] point_y,
    input  logic signed [15:0] point_z,
    input  logic               new_model,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] screen_x,
    output logic signed [15:0] screen_y,
    output logic signed [18:0] depth,
    output logic               on_screen,
    output logic signed [15:0] box_left,
    output logic signed [15:0] box_right,
    output logic signed [15:0] box_top,
    output logic signed [15:0] box_bottom
);
    import ipp_pkg::*;

    logic signed [15:0] offset_x_reg;
    logic signed [15:0] offset_y_reg;
    logic signed [15:0] offset_z_reg;
    logic signed [12:0] center_x_reg;
    logic signed [12:0] center_y_reg;
    logic        [11:0] screen_width_reg;
    logic        [11:0] screen_height_reg;

    logic               a_valid_reg;
    logic signed [15:0] px_reg;
    logic signed [15:0] py_reg;
    logic signed [15:0] pz_reg;
    logic               nm_reg;

    logic               out_valid_reg;
    logic signed [15:0] sx_reg;
    logic signed [15:0] sy_reg;
    logic signed [18:0] depth_reg;
    logic               vis_reg;
    box_t               box_reg;

    logic               out_adv;
    logic               a_move;
    logic               in_take;
    proj_res_t          res_next;

    assign out_adv  = !out_valid_reg || !out_stall;
    assign a_move   = a_valid_reg && out_adv;
    assign in_stall = a_valid_reg && !out_adv;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg      <= '0;
            offset_y_reg      <= '0;
            offset_z_reg      <= '0;
            center_x_reg      <= CENTER_X_RST;
            center_y_reg      <= CENTER_Y_RST;
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OFFSET_X:      offset_x_reg      <= cfg_data;
                REG_OFFSET_Y:      offset_y_reg      <= cfg_data;
                REG_OFFSET_Z:      offset_z_reg      <= cfg_data;
                REG_CENTER_X:      center_x_reg      <= cfg_data[12:0];
                REG_CENTER_Y:      center_y_reg      <= cfg_data[12:0];
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[11:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[11:0];
                default:           ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            px_reg <= point_x;
            py_reg <= point_y;
            pz_reg <= point_z;
            nm_reg <= new_model;
        end
    end

    ipp_proj u_proj (
        .point_x       (px_reg),
        .point_y       (py_reg),
        .point_z       (pz_reg),
        .new_model     (nm_reg),
        .offset_x      (offset_x_reg),
        .offset_y      (offset_y_reg),
        .offset_z      (offset_z_reg),
        .center_x      (center_x_reg),
        .center_y      (center_y_reg),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .box_cur       (box_reg),
        .res           (res_next)
    );

    // result register; the box state is the box output itself
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            box_reg.left   <= BOX_HIGH_INIT;
            box_reg.right  <= BOX_LOW_INIT;
            box_reg.top    <= BOX_HIGH_INIT;
            box_reg.bottom <= BOX_LOW_INIT;
        end
        else if (out_adv)
        begin
            out_valid_reg <= a_valid_reg;
            if (a_valid_reg)
            begin
                box_reg <= res_next.box;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            sx_reg    <= res_next.screen_x;
            sy_reg    <= res_next.screen_y;
            depth_reg <= res_next.depth;
            vis_reg   <= res_next.on_screen;
        end
    end

    assign out_valid  = out_valid_reg;
    assign screen_x   = sx_reg;
    assign screen_y   = sy_reg;
    assign depth      = depth_reg;
    assign on_screen  = vis_reg;
    assign box_left   = box_reg.left;
    assign box_right  = box_reg.right;
    assign box_top    = box_reg.top;
    assign box_bottom = box_reg.bottom;

endmodule
